@@ rtl/wcd_pkg.sv @@
package wcd_pkg;

	localparam int NUM_CODES   = 4;
	localparam int CHIP_W      = 6;
	localparam int TICK_W      = 32;
	localparam int CODE_W      = 64;
	localparam int POS_W       = 6;
	localparam int LEN_W       = POS_W + 1;
	localparam int LOG2_W      = 3;
	localparam int MAX_LOG2    = 6;
	localparam int SUM_W       = 13;
	localparam int IDLE_W      = 16;
	localparam int WAIT_W      = 3;
	localparam int CNT_W       = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int LENS_W      = NUM_CODES * LOG2_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHIPS_0   = 3'd0,
		REG_CHIPS_1   = 3'd1,
		REG_CHIPS_2   = 3'd2,
		REG_CHIPS_3   = 3'd3,
		REG_LEN_LOG2S = 3'd4,
		REG_ENABLE    = 3'd5,
		REG_WAIT      = 3'd6
	} cfg_reg_t;

	localparam logic [WAIT_W-1:0] WAIT_NONE = 3'd4;

	// Symbol-end event of one slot for the current chip.
	typedef struct packed {
		logic hit;
		logic value;
		logic zero;
	} slot_evt_t;

endpackage

@@ rtl/wcd_ifs.sv @@
interface wcd_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [wcd_pkg::CHIP_W-1:0]   chip;
	logic        [wcd_pkg::TICK_W-1:0]   tick_time;

	modport source (output valid, output chip, output tick_time, input ready);
	modport sink   (input valid, input chip, input tick_time, output ready);
	modport mon    (input valid, input chip, input tick_time, input ready);
endinterface

interface wcd_out_if;
	logic                               valid;
	logic                               ready;
	logic [wcd_pkg::NUM_CODES-1:0]      bit_valid_mask;
	logic [wcd_pkg::NUM_CODES-1:0]      bit_value_mask;
	logic [wcd_pkg::IDLE_W-1:0]         idle_count;
	logic                               code_switched;

	modport source (output valid, output bit_valid_mask, output bit_value_mask,
		output idle_count, output code_switched, input ready);
	modport sink   (input valid, input bit_valid_mask, input bit_value_mask,
		input idle_count, input code_switched, output ready);
	modport mon    (input valid, input bit_valid_mask, input bit_value_mask,
		input idle_count, input code_switched, input ready);
endinterface

@@ rtl/wcd_slot.sv @@
module wcd_slot (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [wcd_pkg::CODE_W-1:0]          chips,
	input  logic [wcd_pkg::LOG2_W-1:0]          len_log2,
	input  logic                                active,
	input  logic                                step,
	input  logic                                kill,
	input  logic signed [wcd_pkg::CHIP_W-1:0]   chip,
	input  logic [wcd_pkg::POS_W-1:0]           tick_lo,
	output wcd_pkg::slot_evt_t                  evt
);
	import wcd_pkg::*;

	logic [POS_W-1:0]         pos_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [LOG2_W-1:0]        l2;
	logic [LEN_W-1:0]         len;
	logic [POS_W-1:0]         align_mask;
	logic                     blocked;
	logic                     sym_end;
	logic signed [SUM_W-1:0]  chip_x;
	logic signed [SUM_W-1:0]  sum_nxt;
	logic signed [SUM_W-1:0]  len_x;
	logic                     live;

	always_comb begin
		l2         = (len_log2 > LOG2_W'(MAX_LOG2)) ? LOG2_W'(MAX_LOG2) : len_log2;
		len        = LEN_W'(1) << l2;
		align_mask = POS_W'(len - LEN_W'(1));
		// A slot between symbols waits for a tick aligned to its length.
		blocked    = (pos_q == '0) && ((tick_lo & align_mask) != '0);
		chip_x     = SUM_W'(chip);
		sum_nxt    = chips[pos_q] ? (sum_q + chip_x) : (sum_q - chip_x);
		sym_end    = ({1'b0, pos_q} + LEN_W'(1)) >= len;
		len_x      = $signed(SUM_W'(len));
		live       = active && !blocked && sym_end;
		evt.value  = (sum_nxt == len_x);
		evt.hit    = live && ((sum_nxt == len_x) || (sum_nxt == -len_x));
		evt.zero   = live && (sum_nxt == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
		end else if (step) begin
			if (!active || kill) begin
				pos_q <= '0;
				sum_q <= '0;
			end else if (!blocked) begin
				if (sym_end) begin
					pos_q <= '0;
					sum_q <= '0;
				end else begin
					pos_q <= pos_q + POS_W'(1);
					sum_q <= sum_nxt;
				end
			end
		end
	end

endmodule

@@ rtl/walsh_code_despreader.sv @@
// A request accepted at the input waits in the input register until the output
// register can take it. Throughput: one request per cycle unless the output
// stalls; all four slots correlate in parallel. Input and output registers
// decouple the two sides, so one waiting result does not stop the next request;
// the input stalls only while both hold one. Reset clears slot state, the idle
// counter, the config registers and the valid flags (awaited slot: none).
module walsh_code_despreader (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [wcd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wcd_pkg::CFG_DATA_W-1:0]      cfg_data,
	wcd_in_if.sink                              in_ch,
	wcd_out_if.source                           out_ch
);
	import wcd_pkg::*;

	logic [CODE_W-1:0]        code_chips_q [NUM_CODES];
	logic [LENS_W-1:0]        code_length_log2s_q;
	logic [NUM_CODES-1:0]     code_enable_q;
	logic [WAIT_W-1:0]        wait_slot_q;
	logic                     single_q;
	logic [IDLE_W-1:0]        quiet_q;

	logic                     valid_s1;
	logic signed [CHIP_W-1:0] chip_s1;
	logic [POS_W-1:0]         tick_lo_s1;

	logic                     valid_s2;
	logic [NUM_CODES-1:0]     bit_valid_s2;
	logic [NUM_CODES-1:0]     bit_value_s2;
	logic [IDLE_W-1:0]        idle_s2;
	logic                     switched_s2;

	logic                     advance;
	logic                     in_acc;
	slot_evt_t                evt [NUM_CODES];
	logic [NUM_CODES-1:0]     active;
	logic [NUM_CODES-1:0]     sw;
	logic                     sw_any;
	logic [NUM_CODES-1:0]     kill;
	logic [NUM_CODES-1:0]     hit_m;
	logic [NUM_CODES-1:0]     val_m;
	logic [CNT_W-1:0]         zero_cnt;
	logic                     any_hit;
	logic [IDLE_W:0]          quiet_sum;
	logic [IDLE_W-1:0]        quiet_nxt;

	assign advance      = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || !valid_s2 || out_ch.ready;
	assign in_acc       = in_ch.valid && in_ch.ready;

	for (genvar n = 0; n < NUM_CODES; n++) begin : g_slot
		assign active[n] = single_q ? (wait_slot_q == WAIT_W'(n)) : code_enable_q[n];
		// Only the awaited slot can switch, and only outside single code mode.
		assign sw[n]     = evt[n].hit && !single_q && (wait_slot_q == WAIT_W'(n));
		assign kill[n]   = sw_any && (wait_slot_q != WAIT_W'(n));

		wcd_slot u_slot (
			.clk      (clk),
			.arst_n   (arst_n),
			.chips    (code_chips_q[n]),
			.len_log2 (code_length_log2s_q[LOG2_W*n +: LOG2_W]),
			.active   (active[n]),
			.step     (advance),
			.kill     (kill[n]),
			.chip     (chip_s1),
			.tick_lo  (tick_lo_s1),
			.evt      (evt[n])
		);
	end

	assign sw_any = |sw;

	// Slots after the switching slot do not count on that tick. The idle
	// counter restarts at the last hit and then counts the quiet symbol ends.
	always_comb begin
		zero_cnt = '0;
		any_hit  = 1'b0;
		for (int n = 0; n < NUM_CODES; n++) begin
			hit_m[n] = 1'b0;
			val_m[n] = 1'b0;
			if (!(sw_any && (wait_slot_q < WAIT_W'(n)))) begin
				hit_m[n] = evt[n].hit;
				val_m[n] = evt[n].hit && evt[n].value;
				if (evt[n].hit) begin
					any_hit  = 1'b1;
					zero_cnt = '0;
				end else if (evt[n].zero) begin
					zero_cnt = zero_cnt + CNT_W'(1);
				end
			end
		end
		quiet_sum = {1'b0, (any_hit ? {IDLE_W{1'b0}} : quiet_q)} + (IDLE_W+1)'(zero_cnt);
		quiet_nxt = quiet_sum[IDLE_W] ? {IDLE_W{1'b1}} : quiet_sum[IDLE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < NUM_CODES; n++) begin
				code_chips_q[n] <= '0;
			end
			code_length_log2s_q <= '0;
			code_enable_q       <= '0;
			wait_slot_q         <= WAIT_NONE;
			single_q            <= 1'b0;
			quiet_q             <= '0;
		end else begin
			if (advance) begin
				quiet_q <= quiet_nxt;
				if (sw_any) begin
					single_q <= 1'b1;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_CHIPS_0, REG_CHIPS_1, REG_CHIPS_2, REG_CHIPS_3: begin
						code_chips_q[cfg_index[1:0]] <= cfg_data[CODE_W-1:0];
					end
					REG_LEN_LOG2S: begin
						code_length_log2s_q <= cfg_data[LENS_W-1:0];
					end
					REG_ENABLE: begin
						code_enable_q <= cfg_data[NUM_CODES-1:0];
						single_q      <= 1'b0;
					end
					REG_WAIT: begin
						wait_slot_q <= cfg_data[WAIT_W-1:0];
						single_q    <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ch.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			chip_s1    <= in_ch.chip;
			tick_lo_s1 <= in_ch.tick_time[POS_W-1:0];
		end
		if (advance) begin
			bit_valid_s2 <= hit_m;
			bit_value_s2 <= val_m;
			idle_s2      <= quiet_nxt;
			switched_s2  <= sw_any;
		end
	end

	assign out_ch.valid          = valid_s2;
	assign out_ch.bit_valid_mask = bit_valid_s2;
	assign out_ch.bit_value_mask = bit_value_s2;
	assign out_ch.idle_count     = idle_s2;
	assign out_ch.code_switched  = switched_s2;

endmodule

@@ rtl/wcd_checker.sv @@
module wcd_checker (
	input  logic       clk,
	input  logic       arst_n,
	wcd_in_if.sink     in_ch,
	wcd_out_if.source  out_ch
);
	import wcd_pkg::*;

	// A held result must stay offered until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid)
		else $error("result dropped while stalled");

	a_value_in_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> ((out_ch.bit_value_mask & ~out_ch.bit_valid_mask) == '0))
		else $error("decoded value without a decoded bit");

	// The switching slot decodes last on its tick, so the idle count restarts.
	a_switch_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.code_switched |->
			(out_ch.bit_valid_mask != '0) && (out_ch.idle_count == '0))
		else $error("code switch without a decoded bit");

	// With the output register empty the block always takes a request.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_ch.valid |-> in_ch.ready)
		else $error("input stalled with empty output");

endmodule

bind walsh_code_despreader wcd_checker u_wcd_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.in_ch  (in_ch),
	.out_ch (out_ch)
);
